// ===== hw/rtl/lpab_pkg.sv =====
// ----------------------------------------------------------------------------
// lpab_pkg
// Shared types and constants for the length-prefixed to Annex-B converter.
// ----------------------------------------------------------------------------
package lpab_pkg;

  localparam int unsigned CFG_W      = 3;
  localparam int unsigned SIZE_MAX   = 4;    // widest legal size field, bytes
  localparam int unsigned SC_LEN     = 4;    // start code length, bytes
  localparam int unsigned SC_CNT_W   = 2;    // holds SC_LEN-1
  localparam logic [7:0]  SC_ZERO    = 8'h00;
  localparam logic [7:0]  SC_ONE     = 8'h01;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

  // command passed from the front to the back
  typedef enum logic [1:0] {
    CMD_PAYLOAD = 2'd0,
    CMD_START   = 2'd1,
    CMD_ERROR   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_DRAIN   = 3'b100
  } phase_t;

endpackage

// ===== hw/rtl/lpab_front.sv =====
// ----------------------------------------------------------------------------
// lpab_front
// Parses the length-prefixed byte stream and issues one command per byte
// that causes output: payload byte, start code burst or frame error.
// ----------------------------------------------------------------------------
module lpab_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [7:0]               in_byte,
  input  logic                     in_last,
  input  logic                     cfg_wr_en,
  input  logic [lpab_pkg::CFG_W-1:0] cfg_wr_data,
  output logic                     push,
  output lpab_pkg::cmd_t           cmd
);
  import lpab_pkg::*;

  logic [CFG_W-1:0] cfg_r;
  phase_t           phase_r, phase_nxt;
  logic [2:0]       seen_r, seen_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [31:0]      left_r, left_nxt;

  logic [31:0] acc_shift;
  logic [2:0]  seen_inc;
  logic        cfg_bad;

  assign acc_shift = {acc_r[23:0], in_byte};
  assign seen_inc  = seen_r + 3'd1;
  assign cfg_bad   = (cfg_r == '0) || (cfg_r > CFG_W'(SIZE_MAX));

  always_comb begin
    phase_nxt = phase_r;
    seen_nxt  = seen_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    push      = 1'b0;
    cmd       = '{kind: CMD_PAYLOAD, data: in_byte, last: in_last};
    if (accept) begin
      unique case (phase_r)
        PH_PAYLOAD: begin
          left_nxt = left_r - 32'd1;
          if (left_r == 32'd1) begin
            push      = 1'b1;
            phase_nxt = PH_SIZE;
            seen_nxt  = '0;
            acc_nxt   = '0;
          end else if (in_last) begin
            // frame ends inside a payload: error replaces the byte
            push      = 1'b1;
            cmd       = '{kind: CMD_ERROR, data: 8'h00, last: 1'b1};
            phase_nxt = PH_SIZE;
            seen_nxt  = '0;
            acc_nxt   = '0;
            left_nxt  = '0;
          end else begin
            push = 1'b1;
          end
        end
        PH_SIZE: begin
          if (cfg_bad) begin
            phase_nxt = PH_DRAIN;
          end else begin
            acc_nxt  = acc_shift;
            seen_nxt = seen_inc;
            if (seen_inc >= cfg_r && acc_shift != '0 && !in_last) begin
              push      = 1'b1;
              cmd       = '{kind: CMD_START, data: 8'h00, last: 1'b0};
              left_nxt  = acc_shift;
              seen_nxt  = '0;
              acc_nxt   = '0;
              phase_nxt = PH_PAYLOAD;
            end else if (seen_inc >= cfg_r) begin
              phase_nxt = PH_DRAIN;    // zero size, or size done on last byte
            end else if (in_last) begin
              phase_nxt = PH_DRAIN;    // frame ends inside the size field
            end
          end
          if (phase_nxt == PH_DRAIN && in_last) begin
            push      = 1'b1;
            cmd       = '{kind: CMD_ERROR, data: 8'h00, last: 1'b1};
            phase_nxt = PH_SIZE;
            seen_nxt  = '0;
            acc_nxt   = '0;
            left_nxt  = '0;
          end
        end
        default: begin
          if (in_last) begin
            push      = 1'b1;
            cmd       = '{kind: CMD_ERROR, data: 8'h00, last: 1'b1};
            phase_nxt = PH_SIZE;
            seen_nxt  = '0;
            acc_nxt   = '0;
            left_nxt  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= CFG_RESET;
      phase_r <= PH_SIZE;
      seen_r  <= '0;
      acc_r   <= '0;
      left_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ===== hw/rtl/lpab_cmdq.sv =====
// ----------------------------------------------------------------------------
// lpab_cmdq
// Small command FIFO decoupling the parser from the output sequencer.
// ----------------------------------------------------------------------------
module lpab_cmdq #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpab_pkg::cmd_t push_data,
  input  logic           pop,
  output lpab_pkg::cmd_t pop_data,
  output logic           full,
  output logic           empty
);
  import lpab_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

// ===== hw/rtl/lpab_back.sv =====
// ----------------------------------------------------------------------------
// lpab_back
// Expands commands into output bytes behind a registered output stage.
// A start command yields the four-byte start code 00 00 00 01.
// ----------------------------------------------------------------------------
module lpab_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  lpab_pkg::cmd_t q_data,
  output logic           pop,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic           out_frame_error
);
  import lpab_pkg::*;

  logic                valid_r;
  logic [7:0]          byte_r;
  logic                last_r;
  logic                err_r;
  logic [SC_CNT_W-1:0] remain_r;   // start code bytes still to send
  logic                load;

  assign load = !valid_r || !out_stall;
  assign pop  = load && (remain_r == '0) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      remain_r <= '0;
    end else if (load) begin
      if (remain_r != '0) begin
        valid_r  <= 1'b1;
        byte_r   <= (remain_r == SC_CNT_W'(1)) ? SC_ONE : SC_ZERO;
        last_r   <= 1'b0;
        err_r    <= 1'b0;
        remain_r <= remain_r - SC_CNT_W'(1);
      end else if (!q_empty) begin
        valid_r <= 1'b1;
        unique case (q_data.kind)
          CMD_PAYLOAD: begin
            byte_r <= q_data.data;
            last_r <= q_data.last;
            err_r  <= 1'b0;
          end
          CMD_START: begin
            byte_r   <= SC_ZERO;
            last_r   <= 1'b0;
            err_r    <= 1'b0;
            remain_r <= SC_CNT_W'(SC_LEN - 1);
          end
          default: begin
            byte_r <= 8'h00;
            last_r <= 1'b1;
            err_r  <= 1'b1;
          end
        endcase
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_last        = last_r;
  assign out_frame_error = err_r;

endmodule

// ===== hw/rtl/length_prefixed_to_annexb_nal.sv =====
// Converts length-prefixed NAL units to Annex-B, one input byte per cycle while in_stall is low.
// Each size field (1 to 4 bytes, cfg_wr_data) is replaced by 00 00 00 01 and
// the payload is copied through. A malformed frame produces no further bytes
// and ends with a single transaction carrying out_last and out_frame_error;
// bytes already sent for that frame must be dropped downstream. Payload bytes
// pass at one per cycle while out_stall is low, through the command queue and
// the output register; the three extra start code bytes of each NAL are absorbed
// by the QDEPTH-entry command queue, and in_stall rises only when that queue is full.
// ----------------------------------------------------------------------------
// length_prefixed_to_annexb_nal
// Top level: parser front, command queue, output sequencer back.
// ----------------------------------------------------------------------------
module length_prefixed_to_annexb_nal #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_last,
  output logic                       out_frame_error,
  input  logic                       cfg_wr_en,
  input  logic [lpab_pkg::CFG_W-1:0] cfg_wr_data
);
  import lpab_pkg::*;

  logic q_full, q_empty, push, pop;
  cmd_t push_cmd, pop_cmd;

  assign in_stall = q_full;

  lpab_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_valid && !q_full),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .cmd         (push_cmd)
  );

  lpab_cmdq #(.DEPTH(QDEPTH)) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  lpab_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (pop_cmd),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_frame_error (out_frame_error)
  );

endmodule

// ===== hw/rtl/lpab_checker.sv =====
// ----------------------------------------------------------------------------
// lpab_checker
// Port-level assertions for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module lpab_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_frame_error
);

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_last) && $stable(out_frame_error))
    else $error("stalled output transaction changed");

  // error transaction is always the frame's final, zero byte
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_error |-> out_last && out_byte == 8'h00)
    else $error("malformed error transaction");

  // handshake outputs stay at known levels, as does a valid payload
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_stall, out_valid})
      && (!out_valid || !$isunknown({out_byte, out_last, out_frame_error})))
    else $error("unknown level on an output port");

endmodule

bind length_prefixed_to_annexb_nal lpab_checker u_lpab_checker (.*);
